// File: rtl/sfm_pkg.sv
package sfm_pkg;

  // Input item kinds
  localparam logic KIND_PATTERN = 1'b0;
  localparam logic KIND_TEXT    = 1'b1;

  // ASCII letter range for case folding
  localparam logic [15:0] UPPER_A    = 16'h0041;
  localparam logic [15:0] UPPER_Z    = 16'h005A;
  localparam logic [15:0] CASE_DELTA = 16'h0020;

  // Shift and compare controls shared by every cell of the row
  typedef struct packed {
    logic text_shift;
    logic pat_shift;
    logic exact_cmp;
  } cell_ctrl_t;

  // Fold A..Z to a..z unless the compare is exact
  function automatic logic [15:0] fold_char(input logic [15:0] c, input logic exact);
    logic [15:0] r;
    r = c;
    if (!exact && c >= UPPER_A && c <= UPPER_Z) begin
      r = c + CASE_DELTA;
    end
    return r;
  endfunction

endpackage

// File: rtl/sfm_cell.sv
module sfm_cell (
  input  logic              clk,
  input  sfm_pkg::cell_ctrl_t ctrl,
  input  logic              active,
  input  logic [15:0]       text_in,
  input  logic [15:0]       pat_in,
  output logic [15:0]       text_char,
  output logic [15:0]       pat_char,
  output logic              hit
);
  import sfm_pkg::*;

  // Advance the text window and the reversed pattern one place
  always_ff @(posedge clk) begin
    if (ctrl.text_shift) begin
      text_char <= text_in;
    end
    if (ctrl.pat_shift) begin
      pat_char <= pat_in;
    end
  end

  // Compare the character arriving here against this pattern position
  assign hit = !active ||
               (fold_char(text_in, ctrl.exact_cmp) ==
                fold_char(pat_char, ctrl.exact_cmp));

endmodule

// File: rtl/sfm_chain.sv
module sfm_chain #(
  parameter int MAX_PATTERN = 32,
  parameter int CW          = $clog2(MAX_PATTERN + 1)
) (
  input  logic                clk,
  input  sfm_pkg::cell_ctrl_t ctrl,
  input  logic [15:0]         char_code,
  input  logic [CW-1:0]       pattern_count,
  output logic                all_hit
);
  import sfm_pkg::*;

  logic [15:0]            text_tap [MAX_PATTERN];
  logic [15:0]            pat_tap  [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] hits;

  // Row of cells: cell k holds window position k and pattern position count-1-k
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [15:0] text_in;
    logic [15:0] pat_in;
    logic        active;

    if (k == 0) begin : g_head
      assign text_in = char_code;
      assign pat_in  = char_code;
    end else begin : g_body
      assign text_in = text_tap[k-1];
      assign pat_in  = pat_tap[k-1];
    end

    assign active = (pattern_count > CW'(k));

    sfm_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .active    (active),
      .text_in   (text_in),
      .pat_in    (pat_in),
      .text_char (text_tap[k]),
      .pat_char  (pat_tap[k]),
      .hit       (hits[k])
    );
  end

  // Combine the cell verdicts
  assign all_hit = &hits;

endmodule

// File: rtl/substring_first_match.sv
// First-occurrence search of a stored pattern of 16-bit characters.
// Input channel (in_valid / in_stall) carries pattern and text items; a
// pattern item with first_item set restarts the pattern, later ones append
// (characters beyond MAX_PATTERN are dropped). A text item with first_item
// set opens a new search at base_offset.
// Output channel (out_valid / out_stall) gives one result per search: the
// first match (found, match_start, match_length) or, on the last_item text
// character, not found. Text after a result is dropped until the next first.
// Config channel (cfg_valid / cfg_ready / cfg_data) writes exact_cmp;
// write it only while the block is idle. cfg_ready is always high.
// A result appears in the output register in the cycle after its text
// transaction. One item per cycle while in_stall is low; the whole window is
// compared by the row of MAX_PATTERN cells in the cycle it is shifted.
// in_stall rises only while a result waits in the output register and the
// receiver stalls it; the pending result holds until taken.
// Reset clears the pattern length, the search state and the output valid
// flag, and sets exact_cmp to 1. Window and pattern cells need no
// clearing: only entries written by the current pattern and search are used.
module substring_first_match #(
  parameter int MAX_PATTERN = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [15:0] char_code,
  input  logic        first_item,
  input  logic        last_item,
  input  logic [31:0] base_offset,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        found,
  output logic [31:0] match_start,
  output logic [5:0]  match_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);
  import sfm_pkg::*;

  localparam int CW = $clog2(MAX_PATTERN + 1);

  logic          exact_cmp;
  logic [CW-1:0] pattern_count, pattern_count_next;
  logic [31:0]   chars_seen, chars_seen_next;
  logic [31:0]   end_pos, end_pos_next;
  logic [CW-1:0] fill, fill_next;
  logic          search_finished, search_finished_next;

  logic          in_acc;
  cell_ctrl_t    ctrl;
  logic          all_hit;
  logic          result;
  logic          matched;
  logic [31:0]   start_pos;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid && out_stall;
  assign in_acc    = in_valid && !in_stall;

  // Next state of the pattern length and the search
  always_comb begin
    logic [CW-1:0] pc_base;
    logic [31:0]   cs_base;
    logic [31:0]   end_base;
    logic [CW-1:0] fill_base;
    logic          fin_base;
    logic          sat;

    pc_base   = first_item ? '0 : pattern_count;
    cs_base   = first_item ? '0 : chars_seen;
    end_base  = first_item ? base_offset : end_pos;
    fill_base = first_item ? '0 : fill;
    fin_base  = first_item ? 1'b0 : search_finished;
    sat       = (cs_base == 32'hFFFF_FFFF);

    pattern_count_next   = pattern_count;
    chars_seen_next      = chars_seen;
    end_pos_next         = end_pos;
    fill_next            = fill;
    search_finished_next = search_finished;
    ctrl.text_shift      = 1'b0;
    ctrl.pat_shift       = 1'b0;
    ctrl.exact_cmp       = exact_cmp;

    if (in_acc && kind == KIND_PATTERN) begin
      pattern_count_next = pc_base;
      if (pc_base < CW'(MAX_PATTERN)) begin
        pattern_count_next = pc_base + CW'(1);
        ctrl.pat_shift     = 1'b1;
      end
    end else if (in_acc && kind == KIND_TEXT) begin
      search_finished_next = fin_base;
      if (!fin_base) begin
        ctrl.text_shift = 1'b1;
        chars_seen_next = sat ? cs_base : cs_base + 32'd1;
        end_pos_next    = sat ? end_base : end_base + 32'd1;
        fill_next       = (fill_base == CW'(MAX_PATTERN)) ? fill_base : fill_base + CW'(1);
      end else begin
        chars_seen_next = cs_base;
        end_pos_next    = end_base;
        fill_next       = fill_base;
      end
    end
  end

  // Decide the verdict for the character being shifted in
  assign matched   = ctrl.text_shift && all_hit && (pattern_count != '0) &&
                     (fill_next >= pattern_count);
  assign result    = ctrl.text_shift && (matched || last_item);
  assign start_pos = end_pos_next - 32'(pattern_count);

  sfm_chain #(
    .MAX_PATTERN (MAX_PATTERN),
    .CW          (CW)
  ) u_chain (
    .clk           (clk),
    .ctrl          (ctrl),
    .char_code     (char_code),
    .pattern_count (pattern_count),
    .all_hit       (all_hit)
  );

  // Hold the configuration and the search state
  always_ff @(posedge clk) begin
    if (rst) begin
      exact_cmp       <= 1'b1;
      pattern_count   <= '0;
      chars_seen      <= '0;
      end_pos         <= '0;
      fill            <= '0;
      search_finished <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        exact_cmp <= cfg_data;
      end
      pattern_count   <= pattern_count_next;
      chars_seen      <= chars_seen_next;
      end_pos         <= end_pos_next;
      fill            <= fill_next;
      search_finished <= result ? 1'b1 : search_finished_next;
    end
  end

  // Output register: load a result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result) begin
      found        <= matched;
      match_start  <= matched ? start_pos : 32'd0;
      match_length <= matched ? 6'(pattern_count) : 6'd0;
    end
  end

endmodule

// File: rtl/sfm_checker.sv
module sfm_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        kind,
  input logic        out_valid,
  input logic        out_stall,
  input logic        found,
  input logic [31:0] match_start,
  input logic [5:0]  match_length
);
  import sfm_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(found) &&
    $stable(match_start) && $stable(match_length))
    else $error("stalled result changed");

  // Not found carries zero position and length
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> match_start == 32'd0 && match_length == 6'd0)
    else $error("not-found result with nonzero fields");

  // A match has a nonempty pattern
  a_hit_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> match_length != 6'd0)
    else $error("match with zero length");

  // Input backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a pending result");

  // A new result follows an accepted text transaction
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall && kind == KIND_TEXT))
    else $error("result without a text transaction");

endmodule

bind substring_first_match sfm_checker u_sfm_checker (.*);

// File: tb/sfm_check.sv
`timescale 1ns / 1ps

module sfm_check #(
  parameter int MAX_PATTERN = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        kind,
  input  logic [15:0] char_code,
  input  logic        first_item,
  input  logic        last_item,
  input  logic [31:0] base_offset,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        found,
  input  logic [31:0] match_start,
  input  logic [5:0]  match_length,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_data,
  output int          fail_count,
  output int          results_owed,
  output int          items_taken
);
  import sfm_pkg::*;

  typedef struct {
    logic        found;
    logic [31:0] start;
    logic [5:0]  length;
  } verdict_t;

  // Search verdicts still owed by the block, oldest first
  verdict_t    due_verdicts[$];

  // Mirror of the pattern, the text window and the search state
  logic [15:0] pat_chars [MAX_PATTERN];
  logic [15:0] recent [MAX_PATTERN];
  logic [5:0]  pat_len = '0;
  logic [31:0] seen = '0;
  logic [31:0] origin = '0;
  logic        done = 1'b0;
  logic        exact = 1'b1;
  int          n_fail = 0;
  int          n_taken = 0;

  function automatic logic [15:0] lower(input logic [15:0] c, input logic ex);
    if (!ex && c >= UPPER_A && c <= UPPER_Z) begin
      return c + CASE_DELTA;
    end
    return c;
  endfunction

  // Newest pat_len window characters against the pattern, newest last
  function automatic bit window_hit();
    if (pat_len == 0 || seen < 32'(pat_len)) begin
      return 1'b0;
    end
    for (int k = 0; k < pat_len; k++) begin
      if (lower(recent[k], exact) != lower(pat_chars[pat_len - 1 - k], exact)) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Advance the mirrored search by one accepted transaction
  task automatic advance_search();
    verdict_t v;
    if (kind == KIND_PATTERN) begin
      if (first_item) begin
        pat_len = '0;
      end
      // drop characters beyond the pattern store
      if (pat_len < MAX_PATTERN) begin
        pat_chars[pat_len] = char_code;
        pat_len++;
      end
      n_taken++;
      return;
    end
    if (first_item) begin
      seen   = '0;
      origin = base_offset;
      done   = 1'b0;
    end
    if (done) begin
      return;
    end
    n_taken++;
    for (int k = MAX_PATTERN - 1; k > 0; k--) begin
      recent[k] = recent[k - 1];
    end
    recent[0] = char_code;
    if (seen != '1) begin
      seen++;
    end
    if (window_hit()) begin
      v.found  = 1'b1;
      v.start  = origin + seen - 32'(pat_len);
      v.length = pat_len;
      due_verdicts.push_back(v);
      done = 1'b1;
    end else if (last_item) begin
      v.found  = 1'b0;
      v.start  = '0;
      v.length = '0;
      due_verdicts.push_back(v);
      done = 1'b1;
    end
  endtask

  // Compare one result transaction with the oldest owed verdict
  task automatic compare_verdict();
    verdict_t v;
    if (due_verdicts.size() == 0) begin
      $error("unexpected result: found=%0d match_start=%0h match_length=%0d",
             found, match_start, match_length);
      n_fail++;
      return;
    end
    v = due_verdicts.pop_front();
    if (found !== v.found) begin
      $error("found: expected %0d, actual %0d", v.found, found);
      n_fail++;
    end
    if (match_start !== v.start) begin
      $error("match_start: expected %0h, actual %0h", v.start, match_start);
      n_fail++;
    end
    if (match_length !== v.length) begin
      $error("match_length: expected %0d, actual %0d", v.length, match_length);
      n_fail++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      due_verdicts.delete();
      pat_len = '0;
      seen    = '0;
      origin  = '0;
      done    = 1'b0;
      exact   = 1'b1;
    end else begin
      if (out_valid && !out_stall) begin
        compare_verdict();
      end
      if (cfg_valid && cfg_ready) begin
        exact = cfg_data;
      end
      if (in_valid && !in_stall) begin
        advance_search();
      end
    end
    fail_count   <= n_fail;
    results_owed <= due_verdicts.size();
    items_taken  <= n_taken;
  end

endmodule

// File: tb/tb_substring_first_match.sv
`timescale 1ns / 1ps

module tb_substring_first_match;
  import sfm_pkg::*;

  localparam int LONG_HOLD = 150;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        kind = KIND_PATTERN;
  logic [15:0] char_code = '0;
  logic        first_item = 1'b0;
  logic        last_item = 1'b0;
  logic [31:0] base_offset = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        found;
  logic [31:0] match_start;
  logic [5:0]  match_length;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b1;
  int          fail_count;
  int          results_owed;
  int          items_taken;
  bit          quiet = 1'b0;
  bit          hold_ask = 1'b0;

  substring_first_match dut (.*);

  sfm_check u_check (.*);

  always #2 clk = ~clk;

  // Idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    if (quiet) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 25);
  endfunction

  // Small alphabet around the letter boundaries so that matches are frequent
  function automatic logic [15:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return 16'h0061;
    if (r < 50) return 16'h0062;
    if (r < 62) return 16'h0041;
    if (r < 72) return 16'h0042;
    if (r < 76) return 16'h005A;
    if (r < 80) return 16'h007A;
    if (r < 83) return 16'h0040;
    if (r < 86) return 16'h005B;
    if (r < 88) return 16'h0060;
    if (r < 90) return 16'h007B;
    return 16'($urandom_range(0, 65535));
  endfunction

  // Offer one transaction after a random gap and hold it until taken
  task automatic put_item(input logic k, input logic [15:0] c, input logic f,
                          input logic l, input logic [31:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    kind        <= k;
    char_code   <= c;
    first_item  <= f;
    last_item   <= l;
    base_offset <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait until every owed result has been taken
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (results_owed == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_case(input logic v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed pattern loads and searches, the rest noise
  task automatic run_random(input int goal);
    logic [15:0] pat[$];
    logic [15:0] txt[$];
    logic [31:0] origin;
    logic [15:0] c;
    int          r;
    int          plen;
    int          tlen;
    int          pos;
    bit          abandon;
    while (items_taken < goal) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        pat.delete();
        txt.delete();
        r = $urandom_range(0, 99);
        plen = (r < 80) ? $urandom_range(1, 5) :
               (r < 90) ? $urandom_range(6, 12) : $urandom_range(30, 34);
        repeat (plen) pat.push_back(pick_char());
        foreach (pat[i]) begin
          put_item(KIND_PATTERN, pat[i], i == 0, 1'b0, $urandom);
        end
        tlen = (plen > 12) ? $urandom_range(plen, plen + 8) : $urandom_range(1, 24);
        repeat (tlen) txt.push_back(pick_char());
        // plant the pattern, flipping the case of some letters
        if (plen <= tlen && $urandom_range(0, 2) != 0) begin
          pos = $urandom_range(0, tlen - plen);
          foreach (pat[i]) begin
            c = pat[i];
            if ((c | 16'h0020) >= 16'h0061 && (c | 16'h0020) <= 16'h007A &&
                $urandom_range(0, 1) == 1) begin
              c = c ^ 16'h0020;
            end
            txt[pos + i] = c;
          end
        end
        origin  = $urandom;
        abandon = ($urandom_range(0, 9) == 0);
        foreach (txt[i]) begin
          // occasionally reload the pattern in the middle of the search
          if ($urandom_range(0, 19) == 0) begin
            put_item(KIND_PATTERN, pick_char(), 1'($urandom_range(0, 1)), 1'b0, $urandom);
          end
          put_item(KIND_TEXT, txt[i], i == 0, !abandon && i == tlen - 1,
                   (i == 0) ? origin : 32'($urandom));
        end
      end else if (r < 90) begin
        put_item(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          put_item(KIND_TEXT, pick_char(), 1'b0, $urandom_range(0, 3) == 0, $urandom);
        end
      end
    end
  endtask

  // Receiver: random stalls, one long hold-off on request
  initial begin : receiver
    int n;
    @(posedge clk);
    forever begin
      if (hold_ask) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_ask = 1'b0;
      end else begin
        n = pick_gap();
        out_stall <= (n > 0);
        repeat ((n > 0) ? n : 1) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // text before any search start with an empty pattern: not found
    put_item(KIND_TEXT, 16'h0061, 1'b0, 1'b1, 32'h0);
    // pattern "Ab", matched at the top of the position range
    put_item(KIND_PATTERN, 16'h0041, 1'b1, 1'b0, 32'h0);
    put_item(KIND_PATTERN, 16'h0062, 1'b0, 1'b0, 32'h0);
    put_item(KIND_TEXT, 16'h0078, 1'b1, 1'b0, 32'hFFFF_FFFE);
    put_item(KIND_TEXT, 16'h0041, 1'b0, 1'b0, 32'h0);
    put_item(KIND_TEXT, 16'h0062, 1'b0, 1'b0, 32'h0);
    // ignored once the search has its result
    put_item(KIND_TEXT, 16'h0062, 1'b0, 1'b1, 32'h0);
    // exact compare misses "aB"
    put_item(KIND_TEXT, 16'h0061, 1'b1, 1'b0, 32'h0000_0010);
    put_item(KIND_TEXT, 16'h0042, 1'b0, 1'b1, 32'h0);
    // extreme character codes
    put_item(KIND_PATTERN, 16'hFFFF, 1'b1, 1'b0, 32'hFFFF_FFFF);
    put_item(KIND_PATTERN, 16'h0000, 1'b0, 1'b0, 32'h0);
    put_item(KIND_TEXT, 16'hFFFF, 1'b1, 1'b0, 32'h8000_0000);
    put_item(KIND_TEXT, 16'hFFFF, 1'b0, 1'b0, 32'h0);
    put_item(KIND_TEXT, 16'h0000, 1'b0, 1'b1, 32'h0);
    // pattern reloaded while a search runs
    put_item(KIND_TEXT, 16'h007A, 1'b1, 1'b0, 32'd10);
    put_item(KIND_PATTERN, 16'h007A, 1'b1, 1'b0, 32'h0);
    put_item(KIND_TEXT, 16'h007A, 1'b0, 1'b0, 32'h0);
    // window still holds the previous search: too few characters yet
    put_item(KIND_PATTERN, 16'h0062, 1'b1, 1'b0, 32'h0);
    put_item(KIND_PATTERN, 16'h0062, 1'b0, 1'b0, 32'h0);
    put_item(KIND_TEXT, 16'h0062, 1'b1, 1'b1, 32'd3);
    put_item(KIND_TEXT, 16'h0062, 1'b1, 1'b0, 32'd7);
    put_item(KIND_TEXT, 16'h0062, 1'b0, 1'b1, 32'h0);
    // case folding
    write_case(1'b0);
    put_item(KIND_PATTERN, 16'h0041, 1'b1, 1'b0, 32'h0);
    put_item(KIND_PATTERN, 16'h0062, 1'b0, 1'b0, 32'h0);
    put_item(KIND_TEXT, 16'h0061, 1'b1, 1'b0, 32'd100);
    put_item(KIND_TEXT, 16'h0042, 1'b0, 1'b1, 32'h0);

    // random phases over both compare modes
    write_case(1'b1);
    hold_ask = 1'b1;
    run_random(130);
    write_case(1'b0);
    run_random(240);
    quiet = 1'b1;
    write_case(1'b1);
    run_random(350);
    quiet = 1'b0;
    write_case(1'b0);
    run_random(460);

    settle();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_substring_first_match: done, clean");
    end else begin
      $display("tb_substring_first_match: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("tb_substring_first_match: done, errors");
    $finish;
  end

endmodule
